// ===== rtl/sm83_pkg.sv =====
// Shared types and constants of the SM83 ALU pipeline.
`default_nettype none

package sm83_pkg;

    typedef enum logic [4:0] {
        ACT_ADD   = 5'd0,
        ACT_ADC   = 5'd1,
        ACT_SUB   = 5'd2,
        ACT_SBC   = 5'd3,
        ACT_AND   = 5'd4,
        ACT_OR    = 5'd5,
        ACT_XOR   = 5'd6,
        ACT_CP    = 5'd7,
        ACT_INC   = 5'd8,
        ACT_DEC   = 5'd9,
        ACT_RLCA  = 5'd10,
        ACT_RLA   = 5'd11,
        ACT_RRCA  = 5'd12,
        ACT_RRA   = 5'd13,
        ACT_RLC   = 5'd14,
        ACT_SLA   = 5'd15,
        ACT_SRA   = 5'd16,
        ACT_SRL   = 5'd17,
        ACT_BIT   = 5'd18,
        ACT_ADD16 = 5'd19,
        ACT_ADDSP = 5'd20,
        ACT_INC16 = 5'd21,
        ACT_DEC16 = 5'd22
    } action_t;

    // flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // decoded request: operands already steered onto the shared adder
    typedef struct packed {
        action_t     act;
        logic [15:0] x;
        logic [7:0]  b;
        logic [2:0]  bidx;
        logic [3:0]  flags;
        logic [15:0] opa;
        logic [15:0] opb;
        logic        cin;
    } dec_t;

    // execute results: adder sum with carries, logic/shift unit byte
    typedef struct packed {
        action_t     act;
        logic [15:0] x;
        logic [3:0]  flags;
        logic [15:0] sum;
        logic        c4;
        logic        c8;
        logic        c12;
        logic        c16;
        logic [7:0]  lu8;
        logic        luc;
        logic        bitz;
    } exe_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/sm83_decode.sv =====
// Stage 1: operand steering for the shared 16-bit adder.
`default_nettype none

module sm83_decode (
    input  wire                aclk,
    input  wire                en,
    input  wire [4:0]          action,
    input  wire [15:0]         first_operand,
    input  wire [15:0]         second_operand,
    input  wire [2:0]          bit_index,
    input  wire [3:0]          flags_in,
    output sm83_pkg::dec_t     dec_reg
);

    sm83_pkg::dec_t dec_next;
    logic [7:0]     a;
    logic [7:0]     b;
    logic           c;

    always_comb begin
        a = first_operand[7:0];
        b = second_operand[7:0];
        c = flags_in[sm83_pkg::FLAG_C];
        dec_next.act   = sm83_pkg::action_t'(action);
        dec_next.x     = first_operand;
        dec_next.b     = b;
        dec_next.bidx  = bit_index;
        dec_next.flags = flags_in;
        dec_next.opa   = {8'h00, a};
        dec_next.opb   = {8'h00, b};
        dec_next.cin   = 1'b0;
        unique case (dec_next.act)
            sm83_pkg::ACT_ADD: ;
            sm83_pkg::ACT_ADC: dec_next.cin = c;
            // subtract as a + ~b + 1; carries come out inverted (borrow)
            sm83_pkg::ACT_SUB, sm83_pkg::ACT_CP: begin
                dec_next.opb = {8'h00, ~b};
                dec_next.cin = 1'b1;
            end
            sm83_pkg::ACT_SBC: begin
                dec_next.opb = {8'h00, ~b};
                dec_next.cin = ~c;
            end
            sm83_pkg::ACT_INC: dec_next.opb = 16'h0001;
            sm83_pkg::ACT_DEC: dec_next.opb = 16'h00FF;
            sm83_pkg::ACT_ADD16: begin
                dec_next.opa = first_operand;
                dec_next.opb = second_operand;
            end
            sm83_pkg::ACT_ADDSP: begin
                dec_next.opa = first_operand;
                dec_next.opb = {{8{b[7]}}, b};
            end
            sm83_pkg::ACT_INC16: begin
                dec_next.opa = first_operand;
                dec_next.opb = 16'h0001;
            end
            sm83_pkg::ACT_DEC16: begin
                dec_next.opa = first_operand;
                dec_next.opb = 16'hFFFF;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dec_reg <= dec_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sm83_execute.sv =====
// Stage 2: shared adder with nibble carries, logic and shift unit.
`default_nettype none

module sm83_execute (
    input  wire                aclk,
    input  wire                en,
    input  sm83_pkg::dec_t     dec,
    output sm83_pkg::exe_t     exe_reg
);

    sm83_pkg::exe_t exe_next;
    logic [16:0]    sum17;
    logic [7:0]     a;
    logic           c;

    always_comb begin
        a     = dec.x[7:0];
        c     = dec.flags[sm83_pkg::FLAG_C];
        sum17 = {1'b0, dec.opa} + {1'b0, dec.opb} + {16'h0000, dec.cin};

        exe_next.act   = dec.act;
        exe_next.x     = dec.x;
        exe_next.flags = dec.flags;
        exe_next.sum   = sum17[15:0];
        // carry into bit k recovered from sum and operand bits
        exe_next.c4    = sum17[4]  ^ dec.opa[4]  ^ dec.opb[4];
        exe_next.c8    = sum17[8]  ^ dec.opa[8]  ^ dec.opb[8];
        exe_next.c12   = sum17[12] ^ dec.opa[12] ^ dec.opb[12];
        exe_next.c16   = sum17[16];
        exe_next.bitz  = ~a[dec.bidx];
        exe_next.lu8   = 8'h00;
        exe_next.luc   = 1'b0;
        unique case (dec.act)
            sm83_pkg::ACT_AND: exe_next.lu8 = a & dec.b;
            sm83_pkg::ACT_OR:  exe_next.lu8 = a | dec.b;
            sm83_pkg::ACT_XOR: exe_next.lu8 = a ^ dec.b;
            sm83_pkg::ACT_RLCA, sm83_pkg::ACT_RLC: begin
                exe_next.lu8 = {a[6:0], a[7]};
                exe_next.luc = a[7];
            end
            sm83_pkg::ACT_RLA: begin
                exe_next.lu8 = {a[6:0], c};
                exe_next.luc = a[7];
            end
            sm83_pkg::ACT_SLA: begin
                exe_next.lu8 = {a[6:0], 1'b0};
                exe_next.luc = a[7];
            end
            sm83_pkg::ACT_RRCA: begin
                exe_next.lu8 = {a[0], a[7:1]};
                exe_next.luc = a[0];
            end
            sm83_pkg::ACT_RRA: begin
                exe_next.lu8 = {c, a[7:1]};
                exe_next.luc = a[0];
            end
            sm83_pkg::ACT_SRA: begin
                exe_next.lu8 = {a[7], a[7:1]};
                exe_next.luc = a[0];
            end
            sm83_pkg::ACT_SRL: begin
                exe_next.lu8 = {1'b0, a[7:1]};
                exe_next.luc = a[0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            exe_reg <= exe_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sm83_writeback.sv =====
// Stage 3: result select, zero detect and flag assembly.
`default_nettype none

module sm83_writeback (
    input  wire                aclk,
    input  wire                en,
    input  sm83_pkg::exe_t     exe,
    output sm83_pkg::res_t     res_reg
);

    sm83_pkg::res_t res_next;
    logic           zs;
    logic           zl;
    logic           c;

    always_comb begin
        zs = (exe.sum[7:0] == 8'h00);
        zl = (exe.lu8 == 8'h00);
        c  = exe.flags[sm83_pkg::FLAG_C];
        res_next.result = exe.x;
        res_next.flags  = exe.flags;
        unique case (exe.act)
            sm83_pkg::ACT_ADD, sm83_pkg::ACT_ADC: begin
                res_next.result = {8'h00, exe.sum[7:0]};
                res_next.flags  = {zs, 1'b0, exe.c4, exe.c8};
            end
            sm83_pkg::ACT_SUB, sm83_pkg::ACT_SBC: begin
                res_next.result = {8'h00, exe.sum[7:0]};
                res_next.flags  = {zs, 1'b1, ~exe.c4, ~exe.c8};
            end
            sm83_pkg::ACT_CP:
                res_next.flags = {zs, 1'b1, ~exe.c4, ~exe.c8};
            sm83_pkg::ACT_AND: begin
                res_next.result = {8'h00, exe.lu8};
                res_next.flags  = {zl, 1'b0, 1'b1, 1'b0};
            end
            sm83_pkg::ACT_OR, sm83_pkg::ACT_XOR: begin
                res_next.result = {8'h00, exe.lu8};
                res_next.flags  = {zl, 3'b000};
            end
            sm83_pkg::ACT_INC: begin
                res_next.result = {8'h00, exe.sum[7:0]};
                res_next.flags  = {zs, 1'b0, exe.c4, c};
            end
            sm83_pkg::ACT_DEC: begin
                res_next.result = {8'h00, exe.sum[7:0]};
                res_next.flags  = {zs, 1'b1, ~exe.c4, c};
            end
            // accumulator rotates always clear Z
            sm83_pkg::ACT_RLCA, sm83_pkg::ACT_RLA,
            sm83_pkg::ACT_RRCA, sm83_pkg::ACT_RRA: begin
                res_next.result = {8'h00, exe.lu8};
                res_next.flags  = {3'b000, exe.luc};
            end
            sm83_pkg::ACT_RLC, sm83_pkg::ACT_SLA,
            sm83_pkg::ACT_SRA, sm83_pkg::ACT_SRL: begin
                res_next.result = {8'h00, exe.lu8};
                res_next.flags  = {zl, 2'b00, exe.luc};
            end
            sm83_pkg::ACT_BIT:
                res_next.flags = {exe.bitz, 1'b0, 1'b1, c};
            sm83_pkg::ACT_ADD16: begin
                res_next.result = exe.sum;
                res_next.flags  = {exe.flags[sm83_pkg::FLAG_Z], 1'b0, exe.c12, exe.c16};
            end
            sm83_pkg::ACT_ADDSP: begin
                res_next.result = exe.sum;
                res_next.flags  = {2'b00, exe.c4, exe.c8};
            end
            sm83_pkg::ACT_INC16, sm83_pkg::ACT_DEC16:
                res_next.result = exe.sum;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sm83_alu_with_flags.sv =====
// Top level of the pipelined SM83 ALU with flag generation.
`default_nettype none

// SM83 ALU, three register stages: decode (operand steering onto one shared
// 16-bit adder), execute (adder, nibble carries, logic and shift unit) and
// writeback (result select, zero detect, flags), the last of which is the
// output register. One request is taken every cycle while s_tready is high;
// an accepted request passes the decode, execute and writeback registers on
// its way to m_tvalid. Each stage has its own valid bit and advances when it
// is empty or the next stage advances, so a stall on m_tready holds every
// request in place and s_tready drops only when all three stages are full.
// No state, no reset dependence beyond clearing the valid bits.

module sm83_alu_with_flags (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [15:0] first_operand, [31:16] second_operand, [34:32] bit_index,
    // [38:35] flags_in, [39] zero
    input  wire [39:0]  s_tdata,
    // [4:0] action
    input  wire [4:0]   s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [15:0] result, [19:16] flags_out, [23:20] zero
    output logic [23:0] m_tdata
);

    sm83_pkg::dec_t dec_reg;
    sm83_pkg::exe_t exe_reg;
    sm83_pkg::res_t res_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // a stage may load when it is empty or its contents move on
    assign rdy3     = ~v3_reg | m_tready;
    assign rdy2     = ~v2_reg | rdy3;
    assign rdy1     = ~v1_reg | rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    sm83_decode u_decode (
        .aclk           (aclk),
        .en             (rdy1),
        .action         (s_tuser),
        .first_operand  (s_tdata[15:0]),
        .second_operand (s_tdata[31:16]),
        .bit_index      (s_tdata[34:32]),
        .flags_in       (s_tdata[38:35]),
        .dec_reg        (dec_reg)
    );

    sm83_execute u_execute (
        .aclk    (aclk),
        .en      (rdy2),
        .dec     (dec_reg),
        .exe_reg (exe_reg)
    );

    sm83_writeback u_writeback (
        .aclk    (aclk),
        .en      (rdy3),
        .exe     (exe_reg),
        .res_reg (res_reg)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {4'h0, res_reg.flags, res_reg.result};

endmodule

`default_nettype wire

// ===== rtl/sm83_checker.sv =====
// Port-level checks of the SM83 ALU pipeline, bound to the top level.
`default_nettype none

module sm83_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata
);

    // result held while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // input side blocks only when the output is stalled
    a_back_press: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without output stall");

    // with m_tready high and no new request, the pipeline drains
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready && !(s_tvalid && s_tready)) ##1
        (m_tready && !(s_tvalid && s_tready)) ##1
        (m_tready && !(s_tvalid && s_tready)) |=> !m_tvalid)
        else $error("result appeared with no request in flight");

    // an accepted request reaches m_tvalid if m_tready stays high
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted request did not arrive after three cycles");

endmodule

bind sm83_alu_with_flags sm83_checker u_sm83_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
